// ===== sv/vector_refract_core_defines.svh =====
// assertion helpers for the refraction core
`ifndef VECTOR_REFRACT_CORE_DEFINES_SVH
`define VECTOR_REFRACT_CORE_DEFINES_SVH

// same-cycle implication under reset
`define VRC_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("vector_refract_core check failed");

// next-cycle implication under reset
`define VRC_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("vector_refract_core check failed");

`endif

// ===== sv/vrc_pkg.sv =====
package vrc_pkg;

    localparam int FIELD_W = 20;
    localparam int RATIO_W = 19;
    localparam int IN_W    = 144;
    localparam int OUT_W   = 64;

    // stage map
    localparam int NSTG     = 27;
    localparam int ST_SQ0   = 8;
    localparam int SQ_STGS  = 16;
    localparam int ST_P     = 5;

    localparam logic [42:0] ONE_Q32  = 43'd4294967296;
    localparam logic [63:0] ONE_Q32U = 64'd4294967296;

    typedef logic signed [19:0] t_s20;
    typedef logic [18:0]        t_u19;
    typedef logic signed [31:0] t_s32;
    typedef logic [63:0]        t_u64;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq;

    localparam logic signed [19:0] OUT_MAX = 20'sh7ffff;
    localparam logic signed [19:0] OUT_MIN = 20'sh80000;

endpackage

// ===== sv/vector_refract_core.sv =====
// channel   | dir | tdata fields (low bit up)                        | rate
// s_axis    | in  | dir_x dir_y dir_z norm_x norm_y norm_z index_ratio | 1 / cycle
// m_axis    | out | out_x out_y out_z                                | 1 / cycle
// 27 register stages, among them the 16-stage square root array (two root bits per stage)
// and the multiply stages
// one item enters and one leaves per cycle while the output side keeps up
// reset is synchronous, active low, and clears the stage valid bits only
// a stall on m_axis holds the last stage; empty stages upstream still fill
`include "vector_refract_core_defines.svh"

module vector_refract_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dir_x dir_y dir_z norm_x norm_y norm_z index_ratio, zero pad
    input  logic [vrc_pkg::IN_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_x out_y out_z, zero pad
    output logic [vrc_pkg::OUT_W-1:0] m_axis_tdata
);
    import vrc_pkg::*;

    function automatic t_sq sq_step2(input t_sq s);
        t_sq         o;
        logic [35:0] acc;
        logic [35:0] trial;
        o = s;
        for (int j = 0; j < 2; j++) begin
            acc   = {o.rem, o.rad[63:62]};
            trial = {2'b00, o.root, 2'b01};
            if (acc >= trial) begin
                acc    = acc - trial;
                o.root = {o.root[30:0], 1'b1};
            end else begin
                o.root = {o.root[30:0], 1'b0};
            end
            o.rem = acc[33:0];
            o.rad = {o.rad[61:0], 2'b00};
        end
        return o;
    endfunction

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] adv;

    t_s20 r_d [0:2][0:2];
    t_s20 r_n [0:ST_SQ0+SQ_STGS][0:2];
    t_u19 r_r [0:3];
    t_s32 r_p [ST_P:NSTG-2][0:2];
    t_sq  r_sq [ST_SQ0:ST_SQ0+SQ_STGS];

    logic signed [39:0] r_dn [0:2];
    logic signed [24:0] r_c;
    logic signed [44:0] r_cn [0:2];
    logic signed [28:0] r_inner [0:2];
    logic signed [48:0] r_rp [0:2];
    logic signed [63:0] r_pp [0:2];
    t_u64               r_len2;
    logic signed [52:0] r_qn [0:2];
    t_s20               r_out [0:2];

    t_s20 in_d [0:2];
    t_s20 in_n [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_d[i] = s_axis_tdata[20*i +: 20];
            in_n[i] = s_axis_tdata[60 + 20*i +: 20];
        end
    end

    // a stage moves when it is empty or its successor moves
    always_comb begin
        adv[NSTG-1] = !r_v[NSTG-1] || m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = r_v[NSTG-1];
    assign m_axis_tdata  = {4'b0000, r_out[2], r_out[1], r_out[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // carried operands
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d[0] <= in_d;
            r_n[0] <= in_n;
            r_r[0] <= s_axis_tdata[120 +: 19];
        end
        for (int k = 1; k <= 2; k++) begin
            if (adv[k]) begin
                r_d[k] <= r_d[k-1];
            end
        end
        for (int k = 1; k <= 3; k++) begin
            if (adv[k]) begin
                r_r[k] <= r_r[k-1];
            end
        end
        for (int k = 1; k <= ST_SQ0 + SQ_STGS; k++) begin
            if (adv[k]) begin
                r_n[k] <= r_n[k-1];
            end
        end
    end

    // dot product terms
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_dn[i] <= in_d[i] * in_n[i];
            end
        end
    end

    // cosine: negate, clamp at one, round
    logic signed [42:0] c_full;
    logic signed [42:0] c_rnd;
    always_comb begin
        c_full = -(43'(r_dn[0]) + 43'(r_dn[1]) + 43'(r_dn[2]));
        if (c_full > $signed(ONE_Q32)) begin
            c_full = $signed(ONE_Q32);
        end
        c_rnd = c_full + 43'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_c <= c_rnd[40:16];
        end
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_cn[i] <= r_c * r_n[1][i];
            end
        end
    end

    logic signed [45:0] inner_s [0:2];
    logic signed [48:0] p_s [0:2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            inner_s[i] = (46'(r_d[2][i]) <<< 16) + 46'(r_cn[i]) + 46'sd32768;
            p_s[i]     = r_rp[i] + 49'sd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_inner[i] <= inner_s[i][44:16];
            end
        end
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_rp[i] <= $signed({1'b0, r_r[3]}) * r_inner[i];
            end
        end
        if (adv[ST_P]) begin
            for (int i = 0; i < 3; i++) begin
                r_p[ST_P][i] <= p_s[i][47:16];
            end
        end
        for (int k = ST_P + 1; k <= NSTG - 2; k++) begin
            if (adv[k]) begin
                r_p[k] <= r_p[k-1];
            end
        end
        if (adv[6]) begin
            for (int i = 0; i < 3; i++) begin
                r_pp[i] <= r_p[5][i] * r_p[5][i];
            end
        end
        if (adv[7]) begin
            // wraps mod 2^64 on purpose
            r_len2 <= t_u64'(r_pp[0]) + t_u64'(r_pp[1]) + t_u64'(r_pp[2]);
        end
    end

    // |1 - p.p| seeds the root array
    always_ff @(posedge i_clk) begin
        if (adv[ST_SQ0]) begin
            r_sq[ST_SQ0].rem  <= '0;
            r_sq[ST_SQ0].root <= '0;
            r_sq[ST_SQ0].rad  <= (r_len2 >= ONE_Q32U) ? (r_len2 - ONE_Q32U)
                                                       : (ONE_Q32U - r_len2);
        end
        for (int k = ST_SQ0 + 1; k <= ST_SQ0 + SQ_STGS; k++) begin
            if (adv[k]) begin
                r_sq[k] <= sq_step2(r_sq[k-1]);
            end
        end
    end

    logic signed [53:0] v_s [0:2];
    logic signed [37:0] v_r [0:2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_s[i] = (54'(r_p[NSTG-2][i]) <<< 16) - 54'(r_qn[i]) + 54'sd32768;
            v_r[i] = v_s[i][53:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[NSTG-2]) begin
            for (int i = 0; i < 3; i++) begin
                r_qn[i] <= $signed({1'b0, r_sq[ST_SQ0 + SQ_STGS].root})
                           * r_n[ST_SQ0 + SQ_STGS][i];
            end
        end
        if (adv[NSTG-1]) begin
            for (int i = 0; i < 3; i++) begin
                if (v_r[i] > 38'(OUT_MAX)) begin
                    r_out[i] <= OUT_MAX;
                end else if (v_r[i] < 38'(OUT_MIN)) begin
                    r_out[i] <= OUT_MIN;
                end else begin
                    r_out[i] <= v_r[i][19:0];
                end
            end
        end
    end

    // input back-pressure only when every stage is occupied
    `VRC_ASSERT_NOW(a_full_stall, !s_axis_tready, &r_v)
    // an accepted transaction always lands in the first stage
    `VRC_ASSERT_NEXT(a_first_load, s_axis_tvalid && s_axis_tready, r_v[0])
    // the stage before the output hands its item to the output when the output moves
    `VRC_ASSERT_NEXT(a_last_load, r_v[NSTG-2] && adv[NSTG-1], m_axis_tvalid)

endmodule

// ===== tb/sv/tb_vector_refract_core.sv =====
`timescale 1ns / 1ps

class refract_scoreboard;
    logic [59:0] pending_dirs[$];
    int          n_errors;
    int          n_checked;

    function new();
        n_errors  = 0;
        n_checked = 0;
    endfunction

    static function longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    static function longint sat_q16(longint x);
        if (x > 524287) return 524287;
        if (x < -524288) return -524288;
        return x;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    static function logic [59:0] refract(logic [143:0] item);
        longint          d[3];
        longint          n[3];
        longint          p[3];
        longint          ratio;
        longint          cosv;
        longint          inner;
        longint unsigned len2;
        longint unsigned rad;
        longint          q;
        logic [59:0]     res;
        ratio = longint'(item[138:120]);
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(item[20*i +: 20]));
            n[i] = longint'($signed(item[60 + 20*i +: 20]));
        end
        cosv = -(d[0]*n[0] + d[1]*n[1] + d[2]*n[2]);
        if (cosv > 64'sd4294967296) cosv = 64'sd4294967296;
        cosv = round_q16(cosv);
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            inner = round_q16(d[i] * 65536 + cosv * n[i]);
            p[i]  = round_q16(ratio * inner);
            len2  = len2 + longint'(p[i] * p[i]);
        end
        rad = (len2 >= 64'd4294967296) ? len2 - 64'd4294967296 : 64'd4294967296 - len2;
        q   = longint'(int_sqrt(rad));
        for (int i = 0; i < 3; i++)
            res[20*i +: 20] = 20'(sat_q16(round_q16(p[i] * 65536 - q * n[i])));
        return res;
    endfunction

    function void note_ray(logic [143:0] item);
        pending_dirs.push_back(refract(item));
    endfunction

    function void check_ray(logic [63:0] got);
        logic [59:0] want;
        if (pending_dirs.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
            return;
        end
        want = pending_dirs.pop_front();
        n_checked++;
        for (int i = 0; i < 3; i++)
            if (got[20*i +: 20] !== want[20*i +: 20]) begin
                $display("%0t: out[%0d] expected %h actual %h", $time, i,
                         want[20*i +: 20], got[20*i +: 20]);
                n_errors++;
            end
        if (got[63:60] !== 4'b0) begin
            $display("%0t: pad expected 0 actual %h", $time, got[63:60]);
            n_errors++;
        end
    endfunction
endclass

module tb_vector_refract_core;
    import vrc_pkg::*;

    localparam logic [19:0] ONE_Q16 = 20'h10000;
    localparam logic [19:0] ZERO    = 20'h00000;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;

    refract_scoreboard rays;
    bit                quiet_phase;
    bit                hold_sink;
    int                n_sent;

    vector_refract_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [143:0] pack_ray(logic [19:0] dx, logic [19:0] dy,
        logic [19:0] dz, logic [19:0] nx, logic [19:0] ny, logic [19:0] nz,
        logic [18:0] ratio);
        return {5'b0, ratio, nz, ny, nx, dz, dy, dx};
    endfunction

    // mostly components within +-1.0, sometimes any bits or a full-scale extreme
    function automatic logic [19:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return 20'($signed($urandom_range(0, 131072)) - 65536);
        if (k < 9) return 20'($urandom);
        return ($urandom_range(0, 1) != 0) ? 20'h7ffff : 20'h80000;
    endfunction

    function automatic logic [18:0] rand_ratio();
        if ($urandom_range(0, 9) < 8) return 19'($urandom_range(32768, 131072));
        return 19'($urandom);
    endfunction

    // valid stays high between back-to-back transactions
    task automatic send_ray(logic [143:0] item, bit may_idle);
        if (may_idle && !quiet_phase)
            while ($urandom_range(0, 99) < 9) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rays.note_ray(item);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (rays.pending_dirs.size() != 0) @(posedge i_clk);
    endtask

    // sink: random stalls, except in quiet stretch or long hold
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            rays.check_ray(m_axis_tdata);
        m_axis_tready <= !hold_sink && (quiet_phase || $urandom_range(0, 99) >= 9);
    end

    initial begin
        logic [19:0] c[6];
        rays          = new();
        quiet_phase   = 0;
        hold_sink     = 0;
        n_sent        = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // head-on, grazing, extremes, total internal reflection, cosine clamp
        send_ray(pack_ray(20'hf0000, ZERO, ZERO, ONE_Q16, ZERO, ZERO, 19'h10000), 1);
        send_ray(pack_ray(ZERO, 20'hf0000, ZERO, ZERO, ONE_Q16, ZERO, 19'h0c000), 1);
        send_ray(pack_ray(ONE_Q16, ZERO, ZERO, ZERO, ZERO, ONE_Q16, 19'h18000), 1);
        send_ray(pack_ray(20'h0b505, 20'hf4afb, ZERO, ZERO, ONE_Q16, ZERO, 19'h20000), 1);
        send_ray(pack_ray(20'h80000, 20'h80000, 20'h80000, 20'h7ffff, 20'h7ffff,
                          20'h7ffff, 19'h7ffff), 1);
        send_ray(pack_ray(20'h7ffff, 20'h7ffff, 20'h7ffff, 20'h7ffff, 20'h7ffff,
                          20'h7ffff, 19'h7ffff), 1);
        send_ray(pack_ray(20'h80000, 20'h7ffff, 20'h80000, 20'h80000, 20'h7ffff,
                          20'h80000, 19'h00000), 1);
        send_ray(pack_ray(20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff,
                          20'hfffff, 19'h7ffff), 1);
        send_ray(pack_ray(ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, 19'h00000), 1);
        send_ray(pack_ray(20'he0000, ZERO, ZERO, 20'h20000, ZERO, ZERO, 19'h10000), 1);
        send_ray(pack_ray(20'h20000, ZERO, ZERO, 20'h20000, ZERO, ZERO, 19'h08000), 1);
        send_ray(pack_ray(20'h55555, 20'haaaaa, 20'h55555, 20'haaaaa, 20'h55555,
                          20'haaaaa, 19'h2aaaa), 1);
        send_ray(pack_ray(20'haaaaa, 20'h55555, 20'haaaaa, 20'h55555, 20'haaaaa,
                          20'h55555, 19'h55555), 1);

        // fill the pipe with the sink held off
        hold_sink = 1;
        fork
            begin
                repeat (80) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int k = 0; k < 50; k++) begin
                for (int j = 0; j < 6; j++) c[j] = rand_comp();
                send_ray(pack_ray(c[0], c[1], c[2], c[3], c[4], c[5], rand_ratio()), 0);
            end
        join
        wait_drained();

        for (int k = 0; k < 1400; k++) begin
            quiet_phase = (k >= 500 && k < 700);
            for (int j = 0; j < 6; j++) c[j] = rand_comp();
            send_ray(pack_ray(c[0], c[1], c[2], c[3], c[4], c[5], rand_ratio()), 1);
            if (k == 900) wait_drained();
        end
        quiet_phase = 0;

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("sent %0d rays, checked %0d refracted directions", n_sent, rays.n_checked);
        $display("covered unit, skewed and extreme vectors, reflection and stalls");
        if (rays.n_errors == 0 && rays.pending_dirs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
